// ----- design/circular_record_arena_unit_defines.svh -----
// Assertion macros for the circular record arena checker.
// Included by cra_checker; no other dependencies.
`ifndef CIRCULAR_RECORD_ARENA_UNIT_DEFINES_SVH
`define CIRCULAR_RECORD_ARENA_UNIT_DEFINES_SVH

// implication in the same cycle
`define CRA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// implication on the next cycle
`define CRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/cra_pkg.sv -----
// Shared types and constants for the circular record arena.
// No dependencies.
package cra_pkg;

   localparam int unsigned MEM_BYTES_DEF  = 4096;
   localparam int unsigned META_WIDTH_DEF = 16;

   localparam logic [1:0] REQ_PUSH = 2'd0;
   localparam logic [1:0] REQ_WORD = 2'd1;
   localparam logic [1:0] REQ_POP  = 2'd2;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_LARGE = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_BAD_WORD  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,
      OP_WORD,
      OP_CANCEL,
      OP_ZERO_TB,
      OP_RD_TOPM2,
      OP_WRAP_PREV,
      OP_WRAP_PATCH,
      OP_RD_BOT,
      OP_EV_SUM,
      OP_EV_MOD,
      OP_WR_HDR,
      OP_WR_LEN,
      OP_WR_FOOT,
      OP_WR_PAD_FIN,
      OP_POP_TOP,
      OP_POP_PREV,
      OP_POP_FIX,
      OP_RSP
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_P_LOOP,
      S_W_PREV,
      S_W_PATCH,
      S_FIT,
      S_EV_SUM,
      S_EV_MOD,
      S_WR_LEN,
      S_WR_FOOT,
      S_WR_PAD,
      S_POP_RD,
      S_POP_TOP,
      S_POP_RD2,
      S_POP_PREV,
      S_POP_FIX,
      S_FINISH
   } state_type;

   typedef struct packed {
      op_type     op;
      logic       stat_we;
      status_type stat;
   } cmd_type;

   typedef struct packed {
      logic [1:0] typ;
      logic       pend_nz;
      logic       too_big;
      logic       total_zero;
      logic       wrap_need;
      logic       fits;
      logic       meta_fail;
      logic       mod_more;
      logic       pop_last;
      logic       rsp_busy;
   } sts_type;

endpackage

// ----- design/cra_ctrl.sv -----
// Sequencer for the circular record arena: push, eviction, payload and pop.
// Depends on cra_pkg.
module cra_ctrl import cra_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.op      = OP_NONE;
      cmd.stat_we = 1'b0;
      cmd.stat    = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = OP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.stat_we = 1'b1;
            priority if (sts.typ == REQ_WORD) begin
               if (sts.pend_nz) begin
                  cmd.op   = OP_WORD;
                  cmd.stat = ST_OK;
               end else begin
                  cmd.stat = ST_BAD_WORD;
               end
               state_in = S_FINISH;
            end else if (sts.typ == REQ_PUSH) begin
               cmd.op = OP_CANCEL;
               if (sts.too_big) begin
                  cmd.stat = ST_TOO_LARGE;
                  state_in = S_FINISH;
               end else begin
                  cmd.stat = ST_OK;
                  state_in = S_P_LOOP;
               end
            end else if (sts.typ == REQ_POP) begin
               cmd.op = OP_CANCEL;
               if (sts.total_zero) begin
                  cmd.stat = ST_EMPTY;
                  state_in = S_FINISH;
               end else begin
                  cmd.stat = ST_OK;
                  state_in = S_POP_RD;
               end
            end else begin
               cmd.stat = ST_BAD_WORD;
               state_in = S_FINISH;
            end
         end
         S_P_LOOP: begin
            priority if (sts.total_zero) begin
               cmd.op   = OP_ZERO_TB;
               state_in = S_FIT;
            end else if (sts.wrap_need) begin
               cmd.op   = OP_RD_TOPM2;
               state_in = S_W_PREV;
            end else begin
               state_in = S_FIT;
            end
         end
         S_W_PREV: begin
            cmd.op   = OP_WRAP_PREV;
            state_in = S_W_PATCH;
         end
         S_W_PATCH: begin
            if (sts.meta_fail) begin
               cmd.stat_we = 1'b1;
               cmd.stat    = ST_TOO_LARGE;
               state_in    = S_FINISH;
            end else begin
               cmd.op   = OP_WRAP_PATCH;
               state_in = S_FIT;
            end
         end
         S_FIT: begin
            if (sts.fits) begin
               cmd.op   = OP_WR_HDR;
               state_in = S_WR_LEN;
            end else begin
               cmd.op   = OP_RD_BOT;
               state_in = S_EV_SUM;
            end
         end
         S_EV_SUM: begin
            cmd.op   = OP_EV_SUM;
            state_in = S_EV_MOD;
         end
         S_EV_MOD: begin
            cmd.op = OP_EV_MOD;
            if (!sts.mod_more) begin
               state_in = S_P_LOOP;
            end
         end
         S_WR_LEN: begin
            cmd.op   = OP_WR_LEN;
            state_in = S_WR_FOOT;
         end
         S_WR_FOOT: begin
            cmd.op   = OP_WR_FOOT;
            state_in = S_WR_PAD;
         end
         S_WR_PAD: begin
            cmd.op   = OP_WR_PAD_FIN;
            state_in = S_FINISH;
         end
         S_POP_RD: begin
            cmd.op   = OP_RD_TOPM2;
            state_in = S_POP_TOP;
         end
         S_POP_TOP: begin
            cmd.op   = OP_POP_TOP;
            state_in = sts.pop_last ? S_FINISH : S_POP_RD2;
         end
         S_POP_RD2: begin
            cmd.op   = OP_RD_TOPM2;
            state_in = S_POP_PREV;
         end
         S_POP_PREV: begin
            cmd.op   = OP_POP_PREV;
            state_in = S_POP_FIX;
         end
         S_POP_FIX: begin
            cmd.op   = OP_POP_FIX;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.rsp_busy) begin
               cmd.op   = OP_RSP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- design/cra_dpath.sv -----
// Datapath for the circular record arena: arena memory, offsets, counts, result register.
// Depends on cra_pkg.
module cra_dpath import cra_pkg::*; #(
   parameter int unsigned MEM_BYTES  = MEM_BYTES_DEF,
   parameter int unsigned META_WIDTH = META_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_payload_len,
   input  logic [15:0] req_payload_word,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_block_offset,
   output logic [9:0]  rsp_evicted_count,
   output logic [12:0] rsp_free_bytes,
   output logic [9:0]  rsp_blocks_held
);

   localparam int unsigned WORD_COUNT = MEM_BYTES / 2;
   localparam int unsigned IDX_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int unsigned META_MAX   = (META_WIDTH >= 16) ? 32'hFFFF
                                        : ((32'd1 << META_WIDTH) - 32'd1);
   localparam logic [15:0] META_MASK  = 16'(META_MAX);
   localparam int unsigned SPAN_MAX   = MEM_BYTES & ~32'd1;
   localparam int unsigned SPAN_RST   = (SPAN_MAX > 4096) ? 4096 : SPAN_MAX;

   logic [15:0] mem [WORD_COUNT];

   logic [12:0] span_ff, span_in, top_ff, top_in, bot_ff, bot_in;
   logic [9:0]  total_ff, total_in;
   logic [12:0] fill_ff, fill_in;
   logic [11:0] pend_ff, pend_in;
   logic        pad_ff, pad_in;
   logic [1:0]  typ_ff, typ_in;
   logic [11:0] len_ff, len_in;
   logic [15:0] word_ff, word_in;
   logic [13:0] back_ff, back_in;
   logic [9:0]  evict_ff, evict_in;
   logic [12:0] prev_ff, prev_in;
   logic [16:0] tmp_ff, tmp_in;
   logic [11:0] offs_ff, offs_in;
   status_type  stat_ff, stat_in;
   logic [15:0] rd_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [11:0] rsp_offs_ff, rsp_offs_in;
   logic [9:0]  rsp_evict_ff, rsp_evict_in;
   logic [12:0] rsp_free_ff, rsp_free_in;
   logic [9:0]  rsp_held_ff, rsp_held_in;

   logic [12:0] free_now, bsize, dead, pop_top, span_new;
   logic [15:0] rd_m, diff, mem_wd;
   logic [16:0] patched, bd, fix;
   logic [13:0] mem_addr;
   logic        mem_we, mem_re, addr_ok;
   logic [31:0] word_idx;
   logic [9:0]  total_dec;

   always_comb begin
      if (total_ff == '0) begin
         free_now = span_ff;
      end else if (top_ff > bot_ff) begin
         free_now = span_ff - top_ff + bot_ff;
      end else if (top_ff < bot_ff) begin
         free_now = bot_ff - top_ff;
      end else begin
         free_now = '0;
      end
   end

   assign bsize     = 13'd6 + {1'b0, len_ff} + {12'd0, len_ff[0]};
   assign dead      = span_ff - top_ff;
   assign rd_m      = rd_ff & META_MASK;
   assign patched   = {1'b0, rd_m} + {4'd0, dead};
   assign bd        = {4'd0, bsize} + {4'd0, dead};
   assign fix       = 17'd6 + {1'b0, rd_m} + {16'd0, rd_m[0]};
   assign diff      = rd_m - {3'd0, top_ff};
   assign total_dec = (total_ff != '0) ? total_ff - 10'd1 : '0;

   always_comb begin
      if (rd_m < {3'd0, top_ff}) begin
         pop_top = top_ff - 13'(rd_m);
      end else if (diff <= {3'd0, span_ff}) begin
         pop_top = span_ff - 13'(diff);
      end else begin
         pop_top = '0;
      end
   end

   always_comb begin
      span_new = {csr_wr_data[12:1], 1'b0};
      if (span_new < 13'd8) begin
         span_new = 13'd8;
      end else if (32'(span_new) > SPAN_MAX) begin
         span_new = 13'(SPAN_MAX);
      end
   end

   assign sts.typ        = typ_ff;
   assign sts.pend_nz    = pend_ff != '0;
   assign sts.too_big    = (bsize > span_ff) || (32'(bsize) > META_MAX);
   assign sts.total_zero = total_ff == '0;
   assign sts.wrap_need  = (top_ff > bot_ff) && (bsize > dead);
   assign sts.fits       = bsize <= free_now;
   assign sts.meta_fail  = (32'(patched) > META_MAX) || (32'(bd) > META_MAX);
   assign sts.mod_more   = tmp_ff >= {4'd0, span_ff};
   assign sts.pop_last   = total_ff == 10'd1;
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   always_comb begin
      span_in       = span_ff;
      top_in        = top_ff;
      bot_in        = bot_ff;
      total_in      = total_ff;
      fill_in       = fill_ff;
      pend_in       = pend_ff;
      pad_in        = pad_ff;
      typ_in        = typ_ff;
      len_in        = len_ff;
      word_in       = word_ff;
      back_in       = back_ff;
      evict_in      = evict_ff;
      prev_in       = prev_ff;
      tmp_in        = tmp_ff;
      offs_in       = offs_ff;
      stat_in       = cmd.stat_we ? cmd.stat : stat_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_offs_in   = rsp_offs_ff;
      rsp_evict_in  = rsp_evict_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_held_in   = rsp_held_ff;
      mem_addr      = '0;
      mem_wd        = '0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LATCH: begin
            typ_in   = req_type;
            len_in   = req_payload_len;
            word_in  = req_payload_word;
            evict_in = '0;
            offs_in  = '0;
         end
         OP_WORD: begin
            mem_addr = {1'b0, fill_ff};
            mem_wd   = (pend_ff == 12'd1 && pad_ff) ? {8'd0, word_ff[7:0]} : word_ff;
            mem_we   = 1'b1;
            fill_in  = fill_ff + 13'd2;
            pend_in  = pend_ff - 12'd1;
            if (pend_ff == 12'd1) begin
               pad_in = 1'b0;
            end
         end
         OP_CANCEL: begin
            pend_in = '0;
            pad_in  = 1'b0;
            back_in = {1'b0, bsize};
         end
         OP_ZERO_TB: begin
            top_in = '0;
            bot_in = '0;
         end
         OP_RD_TOPM2: begin
            mem_addr = {1'b0, top_ff} - 14'd2;
            mem_re   = 1'b1;
         end
         OP_WRAP_PREV: begin
            prev_in  = (rd_ff <= {3'd0, top_ff}) ? top_ff - 13'(rd_ff) : '0;
            mem_addr = {1'b0, prev_in};
            mem_re   = 1'b1;
         end
         OP_WRAP_PATCH: begin
            mem_addr = {1'b0, prev_ff};
            mem_wd   = patched[15:0];
            mem_we   = 1'b1;
            back_in  = bd[13:0];
            top_in   = '0;
         end
         OP_RD_BOT: begin
            mem_addr = {1'b0, bot_ff};
            mem_re   = 1'b1;
         end
         OP_EV_SUM: begin
            tmp_in = {4'd0, bot_ff} + {1'b0, rd_m};
         end
         OP_EV_MOD: begin
            if (tmp_ff >= {4'd0, span_ff}) begin
               tmp_in = tmp_ff - {4'd0, span_ff};
            end else begin
               bot_in   = tmp_ff[12:0];
               total_in = total_dec;
               evict_in = evict_ff + 10'd1;
               if (total_dec == '0) begin
                  top_in = '0;
                  bot_in = '0;
               end
            end
         end
         OP_WR_HDR: begin
            mem_addr = {1'b0, top_ff};
            mem_wd   = {3'd0, bsize};
            mem_we   = 1'b1;
         end
         OP_WR_LEN: begin
            mem_addr = {1'b0, top_ff} + 14'd2;
            mem_wd   = {4'd0, len_ff};
            mem_we   = 1'b1;
         end
         OP_WR_FOOT: begin
            mem_addr = {1'b0, top_ff} + {1'b0, bsize} - 14'd2;
            mem_wd   = {2'd0, back_ff};
            mem_we   = 1'b1;
         end
         OP_WR_PAD_FIN: begin
            mem_addr = {1'b0, top_ff} + {2'd0, len_ff} + 14'd3;
            mem_wd   = '0;
            mem_we   = len_ff[0];
            fill_in  = top_ff + 13'd4;
            pend_in  = 12'(({1'b0, len_ff} + 13'd1) >> 1);
            pad_in   = len_ff[0];
            offs_in  = 12'(top_ff + 13'd4);
            top_in   = top_ff + bsize;
            total_in = total_ff + 10'd1;
         end
         OP_POP_TOP: begin
            total_in = total_dec;
            if (total_dec == '0) begin
               top_in = '0;
               bot_in = '0;
            end else begin
               top_in = pop_top;
            end
         end
         OP_POP_PREV: begin
            prev_in  = (rd_m <= {3'd0, top_ff}) ? top_ff - 13'(rd_m) : '0;
            mem_addr = {1'b0, prev_in} + 14'd2;
            mem_re   = 1'b1;
         end
         OP_POP_FIX: begin
            mem_addr = {1'b0, prev_ff};
            mem_wd   = fix[15:0] & META_MASK;
            mem_we   = 1'b1;
         end
         OP_RSP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = stat_ff;
            rsp_offs_in   = offs_ff;
            rsp_evict_in  = evict_ff;
            rsp_free_in   = free_now;
            rsp_held_in   = total_ff;
         end
         default: begin
         end
      endcase
      if (csr_wr_en) begin
         span_in  = span_new;
         top_in   = '0;
         bot_in   = '0;
         total_in = '0;
         fill_in  = '0;
         pend_in  = '0;
         pad_in   = 1'b0;
      end
   end

   assign word_idx = 32'(mem_addr[12:1]);
   assign addr_ok  = !mem_addr[13] && (word_idx < WORD_COUNT);

   always_ff @(posedge clock) begin
      if (mem_we && addr_ok) begin
         mem[word_idx[IDX_W-1:0]] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= addr_ok ? mem[word_idx[IDX_W-1:0]] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff      <= 13'(SPAN_RST);
         top_ff       <= '0;
         bot_ff       <= '0;
         total_ff     <= '0;
         fill_ff      <= '0;
         pend_ff      <= '0;
         pad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         span_ff      <= span_in;
         top_ff       <= top_in;
         bot_ff       <= bot_in;
         total_ff     <= total_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         pad_ff       <= pad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      typ_ff        <= typ_in;
      len_ff        <= len_in;
      word_ff       <= word_in;
      back_ff       <= back_in;
      evict_ff      <= evict_in;
      prev_ff       <= prev_in;
      tmp_ff        <= tmp_in;
      offs_ff       <= offs_in;
      stat_ff       <= stat_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offs_ff   <= rsp_offs_in;
      rsp_evict_ff  <= rsp_evict_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_held_ff   <= rsp_held_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_offset  = rsp_offs_ff;
   assign rsp_evicted_count = rsp_evict_ff;
   assign rsp_free_bytes    = rsp_free_ff;
   assign rsp_blocks_held   = rsp_held_ff;

endmodule

// ----- design/circular_record_arena_unit.sv -----
// Circular record arena: ring of variable-length records in one word memory.
// Payload words, unused and refused items go straight to the result; a pop reads the top
// block and, unless it was the last, patches the previous one; a push also handles wraps
// and evicts blocks by repeated span subtraction (single-port memory); a stalled result adds its stall.
// One item in flight; the next is taken the cycle after the result is loaded.
// Synchronous reset empties the arena; memory contents are not cleared.
module circular_record_arena_unit import cra_pkg::*; #(
   parameter int unsigned MEM_BYTES  = MEM_BYTES_DEF,
   parameter int unsigned META_WIDTH = META_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [11:0] req_payload_len,
   input  logic [15:0] req_payload_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_block_offset,
   output logic [9:0]  rsp_evicted_count,
   output logic [12:0] rsp_free_bytes,
   output logic [9:0]  rsp_blocks_held,
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   cra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cra_dpath #(
      .MEM_BYTES  (MEM_BYTES),
      .META_WIDTH (META_WIDTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_type),
      .req_payload_len   (req_payload_len),
      .req_payload_word  (req_payload_word),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_block_offset  (rsp_block_offset),
      .rsp_evicted_count (rsp_evicted_count),
      .rsp_free_bytes    (rsp_free_bytes),
      .rsp_blocks_held   (rsp_blocks_held)
   );

endmodule

// ----- design/cra_checker.sv -----
// Port-level checks for circular_record_arena_unit, bound to the top level.
// Depends on cra_pkg and circular_record_arena_unit_defines.svh.
`include "circular_record_arena_unit_defines.svh"

module cra_checker import cra_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [11:0] rsp_block_offset,
   input logic [9:0]  rsp_evicted_count,
   input logic [12:0] rsp_free_bytes,
   input logic [9:0]  rsp_blocks_held
);

   `CRA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_free_bytes), "result changed while stalled")
   `CRA_ASSERT_NOW(a_offs_ok, clock, reset, rsp_valid && rsp_status != ST_OK, rsp_block_offset == '0, "offset on a failed item")
   `CRA_ASSERT_NOW(a_empty, clock, reset, rsp_valid && rsp_status == ST_EMPTY, rsp_blocks_held == '0 && rsp_evicted_count == '0, "empty pop with blocks held")
   `CRA_ASSERT_NOW(a_free, clock, reset, rsp_valid && rsp_blocks_held == '0, rsp_free_bytes >= 13'd8, "empty arena reports no space")

endmodule

bind circular_record_arena_unit cra_checker u_cra_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_block_offset  (rsp_block_offset),
   .rsp_evicted_count (rsp_evicted_count),
   .rsp_free_bytes    (rsp_free_bytes),
   .rsp_blocks_held   (rsp_blocks_held)
);
